// ===== hw/rtl/cshc_pkg.sv =====
// cshc_pkg: shared types, constants and the arctangent table of the
// clamped step and heading command block; no dependencies
package cshc_pkg;

  // default parameter values
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  // register indexes and reset values
  localparam logic CFG_STEP_LIMIT = 1'b0;
  localparam logic CFG_TARGET_Z   = 1'b1;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd3840;

  // pi in Q30 radians and the step magnitude limit
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint STEP_MAX = 64'sd65535;

  // tilt limits at the default angle format
  localparam int     ASH_DEF     = 30 - ANGLE_FRAC_BITS_DEF;
  localparam longint TILT_HI_DEF = (PI_Q30 + 3 * (64'sd1 <<< (ASH_DEF - 1)))
                                   / (64'sd3 <<< ASH_DEF);
  localparam longint TILT_LO_DEF = (PI_Q30 + (64'sd1 <<< (ASH_DEF + 1)))
                                   / (64'sd4 <<< ASH_DEF);

  // atan(2^-i) in Q30 radians
  localparam int ATAN_LEN = 24;
  localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
    31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
    31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128
  };

  // side fields that travel with a beat down the pipeline
  typedef struct packed {
    logic signed [23:0] cmd_z;
    logic signed [14:0] tilt;
    logic signed [15:0] gyaw;
    logic               ugy;
    logic               sgnx;
    logic               sgny;
    logic               near_goal;
    logic signed [16:0] smx;
    logic signed [16:0] smy;
  } carry_t;

endpackage

// ===== hw/rtl/clamped_step_and_heading_command.sv =====
// clamped_step_and_heading_command: pipelined step clamp, heading cordic
// and tilt limiter; depends on cshc_pkg
//
//  channel | ports                                   | handshake
//  in      | in_pos_*, in_goal_*, in_pitch, ...      | in_valid / in_stall
//  out     | out_step_*, out_command_*, out_tilt_... | out_valid / out_stall
//  cfg     | cfg_we, cfg_index, cfg_data             | write on cfg_we
//
// one beat enters per cycle while the output is not held; a beat passes through
// the 32 stage square root, the 16 stage divider and the cordic stages
// the whole pipeline moves together; a held result at the output stalls it
// and in_stall follows from that, so nothing is lost or repeated
// reset is synchronous, clears the valid bits and target_z and sets the step limit to 3840
module clamped_step_and_heading_command #(
  parameter int COORD_WIDTH     = cshc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = cshc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = cshc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_goal_x,
  input  logic signed [COORD_WIDTH-1:0] in_goal_y,
  input  logic signed [COORD_WIDTH-1:0] in_goal_z,
  input  logic signed [15:0]            in_pitch,
  input  logic signed [15:0]            in_wanted_tilt,
  input  logic                          in_use_goal_yaw,
  input  logic signed [15:0]            in_goal_yaw,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [16:0]            out_step_x,
  output logic signed [16:0]            out_step_y,
  output logic signed [23:0]            out_command_z,
  output logic signed [15:0]            out_command_yaw,
  output logic signed [14:0]            out_tilt_command
);
  import cshc_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int ASH = 30 - ANGLE_FRAC_BITS;
  localparam int XW  = 35;
  localparam longint PIL     = (PI_Q30 + (64'sd1 <<< (ASH - 1))) >>> ASH;
  localparam longint TILT_HI = (PI_Q30 + 3 * (64'sd1 <<< (ASH - 1)))
                               / (64'sd3 <<< ASH);
  localparam longint TILT_LO = (PI_Q30 + (64'sd1 <<< (ASH + 1)))
                               / (64'sd4 <<< ASH);

  // configuration registers
  logic [15:0]                   step_limit_r;
  logic signed [COORD_WIDTH-1:0] target_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r <= STEP_LIMIT_RST;
      target_z_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STEP_LIMIT) step_limit_r <= cfg_data[15:0];
      else                             target_z_r   <= cfg_data;
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage a: differences and pass-through fields
  logic signed [DW-1:0] a_d0_r, a_d1_r, a_d2_r;
  carry_t               a_c_r, a_c_nxt;
  logic                 a_v_r;
  longint               td, gy, gz;

  always_comb begin
    td = longint'(in_wanted_tilt) - longint'(in_pitch);
    if (td > TILT_HI) td = TILT_HI;
    if (td < -TILT_LO) td = -TILT_LO;
    if (td > 64'sd16383) td = 64'sd16383;
    if (td < -64'sd16384) td = -64'sd16384;
    gy = longint'(in_goal_yaw);
    if (gy > PIL) gy = PIL;
    if (gy < -PIL) gy = -PIL;
    if (gy > 64'sd32767) gy = 64'sd32767;
    if (gy < -64'sd32768) gy = -64'sd32768;
    gz = longint'(in_goal_z);
    if (gz > 64'sd8388607) gz = 64'sd8388607;
    if (gz < -64'sd8388608) gz = -64'sd8388608;
    a_c_nxt       = '0;
    a_c_nxt.cmd_z = gz[23:0];
    a_c_nxt.tilt  = td[14:0];
    a_c_nxt.gyaw  = gy[15:0];
    a_c_nxt.ugy   = in_use_goal_yaw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d0_r <= DW'(in_goal_x) - DW'(in_pos_x);
      a_d1_r <= DW'(in_goal_y) - DW'(in_pos_y);
      a_d2_r <= DW'(target_z_r) - DW'(in_pos_z);
      a_c_r  <= a_c_nxt;
    end
  end

  // stage b: magnitudes, range cut and small-step clamp
  logic [30:0] b_mg0_r, b_mg1_r, b_mg2_r;
  carry_t      b_c_r, b_c_nxt;
  logic        b_v_r;
  logic [63:0] m0, m1, m2;
  logic        ovf;
  longint      cx, cy;

  always_comb begin
    m0  = 64'(a_d0_r[DW-1] ? -a_d0_r : a_d0_r) & ((64'd1 << COORD_WIDTH) - 64'd1);
    m1  = 64'(a_d1_r[DW-1] ? -a_d1_r : a_d1_r) & ((64'd1 << COORD_WIDTH) - 64'd1);
    m2  = 64'(a_d2_r[DW-1] ? -a_d2_r : a_d2_r) & ((64'd1 << COORD_WIDTH) - 64'd1);
    ovf = (m0 >= 64'h8000_0000) || (m1 >= 64'h8000_0000) || (m2 >= 64'h8000_0000);
    if (ovf) begin
      m0 = m0 >> 1;
      m1 = m1 >> 1;
      m2 = m2 >> 1;
    end
    cx = longint'(a_d0_r);
    cy = longint'(a_d1_r);
    if (cx > STEP_MAX) cx = STEP_MAX;
    if (cx < -STEP_MAX) cx = -STEP_MAX;
    if (cy > STEP_MAX) cy = STEP_MAX;
    if (cy < -STEP_MAX) cy = -STEP_MAX;
    b_c_nxt      = a_c_r;
    b_c_nxt.sgnx = a_d0_r[DW-1];
    b_c_nxt.sgny = a_d1_r[DW-1];
    b_c_nxt.smx  = cx[16:0];
    b_c_nxt.smy  = cy[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mg0_r <= m0[30:0];
      b_mg1_r <= m1[30:0];
      b_mg2_r <= m2[30:0];
      b_c_r   <= b_c_nxt;
    end
  end

  // stage c: squares
  logic [61:0] c_sq0_r, c_sq1_r, c_sq2_r;
  logic [31:0] c_limsq_r;
  logic [30:0] c_mgx_r, c_mgy_r;
  carry_t      c_c_r;
  logic        c_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sq0_r   <= 62'(b_mg0_r) * 62'(b_mg0_r);
      c_sq1_r   <= 62'(b_mg1_r) * 62'(b_mg1_r);
      c_sq2_r   <= 62'(b_mg2_r) * 62'(b_mg2_r);
      c_limsq_r <= 32'(step_limit_r) * 32'(step_limit_r);
      c_mgx_r   <= b_mg0_r;
      c_mgy_r   <= b_mg1_r;
      c_c_r     <= b_c_r;
    end
  end

  // stage d (square root entry): sum, limit compare and step products
  logic [63:0] sq_v_r  [0:32];
  logic [63:0] sq_r_r  [0:32];
  logic [46:0] sq_px_r [0:32];
  logic [46:0] sq_py_r [0:32];
  carry_t      sq_c_r  [0:32];
  logic        sq_vl_r [0:32];
  logic [63:0] d_sum;
  carry_t      d_c_nxt;

  always_comb begin
    d_sum             = 64'(c_sq0_r) + 64'(c_sq1_r) + 64'(c_sq2_r);
    d_c_nxt           = c_c_r;
    d_c_nxt.near_goal = d_sum <= 64'(c_limsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vl_r[0] <= 1'b0;
    else if (en) sq_vl_r[0] <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v_r[0]  <= d_sum;
      sq_r_r[0]  <= '0;
      sq_px_r[0] <= 47'(c_mgx_r) * 47'(step_limit_r);
      sq_py_r[0] <= 47'(c_mgy_r) * 47'(step_limit_r);
      sq_c_r[0]  <= d_c_nxt;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic [63:0] bitv, t, v_nxt, r_nxt;
    always_comb begin
      bitv = 64'd1 << (62 - 2 * k);
      t    = sq_r_r[k] + bitv;
      if (sq_v_r[k] >= t) begin
        v_nxt = sq_v_r[k] - t;
        r_nxt = (sq_r_r[k] >> 1) + bitv;
      end else begin
        v_nxt = sq_v_r[k];
        r_nxt = sq_r_r[k] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vl_r[k+1] <= 1'b0;
      else if (en) sq_vl_r[k+1] <= sq_vl_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_v_r[k+1]  <= v_nxt;
        sq_r_r[k+1]  <= r_nxt;
        sq_px_r[k+1] <= sq_px_r[k];
        sq_py_r[k+1] <= sq_py_r[k];
        sq_c_r[k+1]  <= sq_c_r[k];
      end
    end
  end

  // stage p: rounded numerators and divisor
  logic [48:0] dv_nx_r [0:16];
  logic [48:0] dv_ny_r [0:16];
  logic [32:0] dv_dn_r [0:16];
  logic [15:0] dv_qx_r [0:16];
  logic [15:0] dv_qy_r [0:16];
  carry_t      dv_c_r  [0:16];
  logic        dv_vl_r [0:16];
  logic [31:0] p_n;

  assign p_n = (sq_r_r[32][31:0] == 32'd0) ? 32'd1 : sq_r_r[32][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vl_r[0] <= 1'b0;
    else if (en) dv_vl_r[0] <= sq_vl_r[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_nx_r[0] <= {1'b0, sq_px_r[32], 1'b0} + 49'(p_n);
      dv_ny_r[0] <= {1'b0, sq_py_r[32], 1'b0} + 49'(p_n);
      dv_dn_r[0] <= {p_n, 1'b0};
      dv_qx_r[0] <= '0;
      dv_qy_r[0] <= '0;
      dv_c_r[0]  <= sq_c_r[32];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < 16; j++) begin : g_div
    logic [48:0] sh, nx_nxt, ny_nxt;
    logic        bx, by;
    always_comb begin
      sh     = 49'(dv_dn_r[j]) << (15 - j);
      bx     = dv_nx_r[j] >= sh;
      by     = dv_ny_r[j] >= sh;
      nx_nxt = bx ? dv_nx_r[j] - sh : dv_nx_r[j];
      ny_nxt = by ? dv_ny_r[j] - sh : dv_ny_r[j];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vl_r[j+1] <= 1'b0;
      else if (en) dv_vl_r[j+1] <= dv_vl_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_nx_r[j+1] <= nx_nxt;
        dv_ny_r[j+1] <= ny_nxt;
        dv_dn_r[j+1] <= dv_dn_r[j];
        dv_qx_r[j+1] <= {dv_qx_r[j][14:0], bx};
        dv_qy_r[j+1] <= {dv_qy_r[j][14:0], by};
        dv_c_r[j+1]  <= dv_c_r[j];
      end
    end
  end

  // stage s: step select
  logic signed [16:0] s_stx_r, s_sty_r;
  carry_t             s_c_r;
  logic               s_v_r;
  logic signed [16:0] qxs, qys;

  always_comb begin
    qxs = $signed({1'b0, dv_qx_r[16]});
    qys = $signed({1'b0, dv_qy_r[16]});
    if (dv_c_r[16].sgnx) qxs = -qxs;
    if (dv_c_r[16].sgny) qys = -qys;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (en) s_v_r <= dv_vl_r[16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_stx_r <= dv_c_r[16].near_goal ? dv_c_r[16].smx : qxs;
      s_sty_r <= dv_c_r[16].near_goal ? dv_c_r[16].smy : qys;
      s_c_r   <= dv_c_r[16];
    end
  end

  // cordic entry: scale, fold the left half plane
  logic signed [XW-1:0] co_x_r [0:CORDIC_STAGES];
  logic signed [XW-1:0] co_y_r [0:CORDIC_STAGES];
  logic signed [XW-1:0] co_z_r [0:CORDIC_STAGES];
  logic signed [16:0]   co_sx_r [0:CORDIC_STAGES];
  logic signed [16:0]   co_sy_r [0:CORDIC_STAGES];
  logic                 co_zero_r [0:CORDIC_STAGES];
  carry_t               co_c_r [0:CORDIC_STAGES];
  logic                 co_vl_r [0:CORDIC_STAGES];
  logic signed [XW-1:0] e_x, e_y, e_z;

  always_comb begin
    e_x = XW'(s_stx_r) <<< 14;
    e_y = XW'(s_sty_r) <<< 14;
    e_z = '0;
    if (e_x < 0) begin
      e_z = (e_y >= 0) ? XW'(PI_Q30) : -XW'(PI_Q30);
      e_x = -e_x;
      e_y = -e_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) co_vl_r[0] <= 1'b0;
    else if (en) co_vl_r[0] <= s_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_x_r[0]    <= e_x;
      co_y_r[0]    <= e_y;
      co_z_r[0]    <= e_z;
      co_sx_r[0]   <= s_stx_r;
      co_sy_r[0]   <= s_sty_r;
      co_zero_r[0] <= (s_stx_r == 17'sd0) && (s_sty_r == 17'sd0);
      co_c_r[0]    <= s_c_r;
    end
  end

  // vectoring cordic, one rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [XW-1:0] ys, xs, at;
    always_comb begin
      ys = co_y_r[i] >>> i;
      xs = co_x_r[i] >>> i;
      at = XW'(ATAN_Q30[i]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) co_vl_r[i+1] <= 1'b0;
      else if (en) co_vl_r[i+1] <= co_vl_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (co_y_r[i] > 0) begin
          co_x_r[i+1] <= co_x_r[i] + ys;
          co_y_r[i+1] <= co_y_r[i] - xs;
          co_z_r[i+1] <= co_z_r[i] + at;
        end else begin
          co_x_r[i+1] <= co_x_r[i] - ys;
          co_y_r[i+1] <= co_y_r[i] + xs;
          co_z_r[i+1] <= co_z_r[i] - at;
        end
        co_sx_r[i+1]   <= co_sx_r[i];
        co_sy_r[i+1]   <= co_sy_r[i];
        co_zero_r[i+1] <= co_zero_r[i];
        co_c_r[i+1]    <= co_c_r[i];
      end
    end
  end

  // output stage: heading rounding, yaw select
  logic signed [16:0] o_sx_r, o_sy_r;
  logic signed [23:0] o_z_r;
  logic signed [15:0] o_yaw_r;
  logic signed [14:0] o_tilt_r;
  logic signed [15:0] f_yaw;
  longint             hz;
  carry_t             fc;

  always_comb begin
    fc = co_c_r[CORDIC_STAGES];
    hz = (longint'(co_z_r[CORDIC_STAGES]) + (64'sd1 <<< (ASH - 1))) >>> ASH;
    if (hz > PIL) hz = PIL;
    if (hz < -PIL) hz = -PIL;
    if (hz > 64'sd32767) hz = 64'sd32767;
    if (hz < -64'sd32768) hz = -64'sd32768;
    if (co_zero_r[CORDIC_STAGES]) hz = '0;
    f_yaw = fc.ugy ? fc.gyaw : hz[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= co_vl_r[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_sx_r   <= co_sx_r[CORDIC_STAGES];
      o_sy_r   <= co_sy_r[CORDIC_STAGES];
      o_z_r    <= fc.cmd_z;
      o_yaw_r  <= f_yaw;
      o_tilt_r <= fc.tilt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_x       = o_sx_r;
  assign out_step_y       = o_sy_r;
  assign out_command_z    = o_z_r;
  assign out_command_yaw  = o_yaw_r;
  assign out_tilt_command = o_tilt_r;

endmodule

// ===== hw/rtl/cshc_checker.sv =====
// cshc_checker: port-level checks of the clamped step and heading block
// and its bind; depends on cshc_pkg
module cshc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] out_tilt_command
);
  import cshc_pkg::*;

  // a held result keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tilt_command))
    else $error("held result changed");

  // back-pressure at the output reaches the input
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output held");

  // an empty output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // tilt stays inside its limits
  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (longint'(out_tilt_command) <= TILT_HI_DEF) &&
                  (longint'(out_tilt_command) >= -TILT_LO_DEF))
    else $error("tilt out of range");

endmodule

bind clamped_step_and_heading_command cshc_checker u_cshc_checker (.*);

// ===== verif/tb.sv =====
// tb: self-checking bench for clamped_step_and_heading_command; needs only
// the rtl and cshc_pkg; predicts each command beat and compares in order
module tb;
  import cshc_pkg::*;

  typedef struct packed {
    logic signed [23:0] pos_x, pos_y, pos_z, goal_x, goal_y, goal_z;
    logic signed [15:0] pitch, wanted_tilt;
    logic               use_goal_yaw;
    logic signed [15:0] goal_yaw;
  } tick_t;

  typedef struct packed {
    logic signed [16:0] step_x, step_y;
    logic signed [23:0] command_z;
    logic signed [15:0] command_yaw;
    logic signed [14:0] tilt_command;
  } command_t;

  localparam int LATENCY = 56 + CORDIC_STAGES_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_STEP_LIMIT;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  tick_t tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  command_t got;

  // current register copies
  longint step_limit = 3840;
  longint target_z = 0;

  command_t pending_commands[$];
  int mismatches = 0;
  bit calm = 1'b0;

  clamped_step_and_heading_command uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(tick.pos_x), .in_pos_y(tick.pos_y), .in_pos_z(tick.pos_z),
    .in_goal_x(tick.goal_x), .in_goal_y(tick.goal_y), .in_goal_z(tick.goal_z),
    .in_pitch(tick.pitch), .in_wanted_tilt(tick.wanted_tilt),
    .in_use_goal_yaw(tick.use_goal_yaw), .in_goal_yaw(tick.goal_yaw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_step_x(got.step_x), .out_step_y(got.step_y),
    .out_command_z(got.command_z), .out_command_yaw(got.command_yaw),
    .out_tilt_command(got.tilt_command)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint pi_q13();
    return (PI_Q30 + (64'sd1 <<< 16)) >>> 17;
  endfunction

  // vectoring cordic on the step, q30 radians rounded to q13
  function automatic longint step_heading(longint sx, longint sy);
    longint x, y, z, nx;
    z = 0;
    if (sx == 0 && sy == 0) return 0;
    x = sx * 16384;
    y = sy * 16384;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_Q30[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    return clamp((z + (64'sd1 <<< 16)) >>> 17, -pi_q13(), pi_q13());
  endfunction

  function automatic longint scaled_part(longint d, longint unsigned n);
    longint unsigned m, q;
    m = d < 0 ? -d : d;
    q = (m * longint'(step_limit) * 2 + n) / (2 * n);
    if (q > STEP_MAX) q = STEP_MAX;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic command_t predict_command(tick_t t);
    command_t c;
    longint d[3], mg[3], sx, sy, yaw;
    longint unsigned sq, n;
    d[0] = longint'(t.goal_x) - longint'(t.pos_x);
    d[1] = longint'(t.goal_y) - longint'(t.pos_y);
    d[2] = target_z - longint'(t.pos_z);
    for (int k = 0; k < 3; k++) mg[k] = d[k] < 0 ? -d[k] : d[k];
    while (mg[0] >= (64'sd1 <<< 31) || mg[1] >= (64'sd1 <<< 31) ||
           mg[2] >= (64'sd1 <<< 31))
      for (int k = 0; k < 3; k++) mg[k] >>= 1;
    sq = 0;
    for (int k = 0; k < 3; k++) sq += mg[k] * mg[k];
    if (sq <= step_limit * step_limit) begin
      sx = clamp(d[0], -STEP_MAX, STEP_MAX);
      sy = clamp(d[1], -STEP_MAX, STEP_MAX);
    end else begin
      n = root_floor(sq);
      if (n == 0) n = 1;
      sx = scaled_part(d[0] < 0 ? -mg[0] : mg[0], n);
      sy = scaled_part(d[1] < 0 ? -mg[1] : mg[1], n);
    end
    if (t.use_goal_yaw) yaw = clamp(longint'(t.goal_yaw), -pi_q13(), pi_q13());
    else yaw = step_heading(sx, sy);
    c.step_x = 17'(clamp(sx, -65536, 65535));
    c.step_y = 17'(clamp(sy, -65536, 65535));
    c.command_z = t.goal_z;
    c.command_yaw = 16'(clamp(yaw, -32768, 32767));
    c.tilt_command = 15'(clamp(clamp(longint'(t.wanted_tilt) - longint'(t.pitch),
                                     -TILT_LO_DEF, TILT_HI_DEF), -16384, 16383));
    return c;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] seen);
    mismatches++;
    $display("mismatch %s: expected %0d got %0d", what, $signed(want), $signed(seen));
  endtask

  // output side: random stall bursts and in-order comparison
  int stall_left = 0;
  always @(posedge clk) begin
    command_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_commands.size() == 0) begin
        mismatches++;
        $display("mismatch: command beat with nothing pending");
      end else begin
        w = pending_commands.pop_front();
        if (got.step_x !== w.step_x) report("step_x", 32'(w.step_x), 32'(got.step_x));
        if (got.step_y !== w.step_y) report("step_y", 32'(w.step_y), 32'(got.step_y));
        if (got.command_z !== w.command_z)
          report("command_z", 32'(w.command_z), 32'(got.command_z));
        if (got.command_yaw !== w.command_yaw)
          report("command_yaw", 32'(w.command_yaw), 32'(got.command_yaw));
        if (got.tilt_command !== w.tilt_command)
          report("tilt_command", 32'(w.tilt_command), 32'(got.tilt_command));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one input beat, with an occasional gap before it
  task automatic send_tick(tick_t t);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (in_stall);
    pending_commands.insert(pending_commands.size(), predict_command(t));
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_commands.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_LIMIT) step_limit = longint'(val[15:0]);
    else target_z = longint'($signed(val));
  endtask

  // random tick: mostly goals near the position, some anywhere
  function automatic tick_t random_tick();
    tick_t t;
    int span;
    t.pos_x = 24'($urandom());
    t.pos_y = 24'($urandom());
    t.pos_z = 24'($urandom());
    t.goal_z = 24'($urandom());
    span = $urandom_range(0, 3) == 0 ? 300 : 20000;
    if ($urandom_range(0, 3) == 0) begin
      t.goal_x = 24'($urandom());
      t.goal_y = 24'($urandom());
    end else begin
      t.goal_x = 24'(t.pos_x + $signed($urandom_range(0, 2 * span)) - span);
      t.goal_y = 24'(t.pos_y + $signed($urandom_range(0, 2 * span)) - span);
      if ($urandom_range(0, 1))
        t.pos_z = 24'(target_z - longint'($urandom_range(0, span)));
    end
    if ($urandom_range(0, 3) == 0) begin
      t.pitch = 16'($urandom());
      t.wanted_tilt = 16'($urandom());
      t.goal_yaw = 16'($urandom());
    end else begin
      t.pitch = 16'(int'($urandom_range(0, 51472)) - 25736);
      t.wanted_tilt = 16'(int'($urandom_range(0, 51472)) - 25736);
      t.goal_yaw = 16'(int'($urandom_range(0, 51472)) - 25736);
    end
    t.use_goal_yaw = $urandom_range(0, 3) == 0;
    return t;
  endfunction

  function automatic tick_t make_tick(longint px, longint py, longint gx, longint gy,
                                      longint pt, longint wt, bit ug, longint gyaw);
    tick_t t;
    t.pos_x = 24'(px); t.pos_y = 24'(py); t.pos_z = 24'(target_z);
    t.goal_x = 24'(gx); t.goal_y = 24'(gy); t.goal_z = 24'(gx);
    t.pitch = 16'(pt); t.wanted_tilt = 16'(wt);
    t.use_goal_yaw = ug; t.goal_yaw = 16'(gyaw);
    return t;
  endfunction

  // zero difference, quadrants, field extremes, tilt and yaw limits
  task automatic test_directed();
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(5, 5, 5, 5, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 100, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, -100, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 100, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, -100, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, -100, -1, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 3840, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 3841, 0, 0, 0, 0, 0));
    send_tick(make_tick(-8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0));
    send_tick(make_tick(8388607, 8388607, -8388608, -8388608, 0, 0, 0, 0));
    send_tick(make_tick(8388607, -8388608, -8388608, 8388607, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, -25736, 25736, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 25736, -25736, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, -32768, 32767, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 32767, -32768, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 100, 100, 1, 32767));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, -32768));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, 25736));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 1, -25736));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_tick(random_tick());
  endtask

  // step limit at zero, full scale and one
  task automatic test_step_limit_extremes();
    write_reg(CFG_STEP_LIMIT, 24'd0);
    test_directed();
    test_random(100);
    write_reg(CFG_STEP_LIMIT, 24'd65535);
    test_directed();
    test_random(200);
    write_reg(CFG_STEP_LIMIT, 24'd1);
    test_random(100);
  endtask

  // direction point height at both ends, then a random value with a random step limit
  task automatic test_target_z_extremes();
    write_reg(CFG_TARGET_Z, 24'h800000);
    test_random(150);
    write_reg(CFG_TARGET_Z, 24'h7fffff);
    test_random(150);
    write_reg(CFG_STEP_LIMIT, 24'($urandom_range(0, 65535)));
    write_reg(CFG_TARGET_Z, 24'($urandom()));
    test_random(200);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_step_limit_extremes();
    test_target_z_extremes();
    write_reg(CFG_TARGET_Z, 24'd0);
    write_reg(CFG_STEP_LIMIT, 24'd3840);
    calm = 1'b1;
    test_random(200);
    drain();
    if (mismatches == 0 && pending_commands.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard limit on run length
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
